>>> hw/rtl/tsdp_pkg.sv
// ----------------------------------------------------------------------------
// tsdp_pkg
// shared constants, types and function of the ternary sign dot product
// ----------------------------------------------------------------------------
package tsdp_pkg;

    localparam int CHUNK_ELEMENTS = 32;
    localparam int LANE_COUNT     = CHUNK_ELEMENTS / 2;
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = 64;
    localparam int ACC_W          = 16;
    localparam int GROUP_SIZE     = 4;
    localparam int GROUP_COUNT    = LANE_COUNT / GROUP_SIZE;
    localparam int PART_W         = ACC_W + $clog2(GROUP_SIZE);
    localparam int DOT_W          = PART_W + $clog2(GROUP_COUNT);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic snap_valid;
        logic part_valid;
        logic dot_valid;
    } merge_status_t;

    // weight sign picks activation, its negation or zero
    function automatic byte_t sign_select(input byte_t act, input byte_t wgt);
        byte_t r;
        if (wgt[BYTE_W-1])
        begin
            r = byte_t'(~act + byte_t'(1));
        end
        else if (wgt == '0)
        begin
            r = '0;
        end
        else
        begin
            r = act;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/tsdp_chunk_if.sv
// ----------------------------------------------------------------------------
// tsdp_chunk_if
// request channel carrying one 32-element chunk of activations and weights
// ----------------------------------------------------------------------------
interface tsdp_chunk_if;
    logic        valid;
    logic        ready;
    logic [63:0] act_word0;
    logic [63:0] act_word1;
    logic [63:0] act_word2;
    logic [63:0] act_word3;
    logic [63:0] wgt_word0;
    logic [63:0] wgt_word1;
    logic [63:0] wgt_word2;
    logic [63:0] wgt_word3;
    logic        last_chunk;

    modport source (
        output valid, act_word0, act_word1, act_word2, act_word3,
               wgt_word0, wgt_word1, wgt_word2, wgt_word3, last_chunk,
        input  ready
    );

    modport sink (
        input  valid, act_word0, act_word1, act_word2, act_word3,
               wgt_word0, wgt_word1, wgt_word2, wgt_word3, last_chunk,
        output ready
    );
endinterface

>>> hw/rtl/tsdp_result_if.sv
// ----------------------------------------------------------------------------
// tsdp_result_if
// handshake channel carrying one dot product result
// ----------------------------------------------------------------------------
interface tsdp_result_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] dot_sum;

    modport source (
        output valid, dot_sum,
        input  ready
    );

    modport sink (
        input  valid, dot_sum,
        output ready
    );
endinterface

>>> hw/rtl/tsdp_lane.sv
// ----------------------------------------------------------------------------
// tsdp_lane
// one accumulator lane: two sign selects added into a wrapping 16-bit sum
// ----------------------------------------------------------------------------
module tsdp_lane (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           last,
    input  tsdp_pkg::byte_t act_lo,
    input  tsdp_pkg::byte_t act_hi,
    input  tsdp_pkg::byte_t wgt_lo,
    input  tsdp_pkg::byte_t wgt_hi,
    output tsdp_pkg::acc_t  lane_sum
);

    tsdp_pkg::acc_t  acc_reg;
    tsdp_pkg::acc_t  acc_next;
    tsdp_pkg::byte_t sel_lo;
    tsdp_pkg::byte_t sel_hi;

    always_comb
    begin
        sel_lo   = tsdp_pkg::sign_select(act_lo, wgt_lo);
        sel_hi   = tsdp_pkg::sign_select(act_hi, wgt_hi);
        acc_next = acc_reg
                 + {{(tsdp_pkg::ACC_W - tsdp_pkg::BYTE_W){sel_lo[tsdp_pkg::BYTE_W-1]}}, sel_lo}
                 + {{(tsdp_pkg::ACC_W - tsdp_pkg::BYTE_W){sel_hi[tsdp_pkg::BYTE_W-1]}}, sel_hi};
    end

    assign lane_sum = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (en)
        begin
            acc_reg <= last ? '0 : acc_next;
        end
    end

endmodule

>>> hw/rtl/tsdp_merge.sv
// ----------------------------------------------------------------------------
// tsdp_merge
// registered adder tree summing the sixteen lane snapshots into one result
// ----------------------------------------------------------------------------
module tsdp_merge (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  tsdp_pkg::acc_t          lane_sum [tsdp_pkg::LANE_COUNT],
    output logic                    load_ready,
    output tsdp_pkg::merge_status_t status,
    tsdp_result_if.source           result
);

    tsdp_pkg::acc_t                     snap_reg [tsdp_pkg::LANE_COUNT];
    logic signed [tsdp_pkg::PART_W-1:0] part_reg [tsdp_pkg::GROUP_COUNT];
    logic signed [tsdp_pkg::PART_W-1:0] part_next [tsdp_pkg::GROUP_COUNT];
    logic signed [tsdp_pkg::DOT_W-1:0]  dot_reg;
    logic signed [tsdp_pkg::DOT_W-1:0]  dot_next;
    logic                               snap_valid_reg;
    logic                               part_valid_reg;
    logic                               dot_valid_reg;
    logic                               snap_move;
    logic                               part_move;
    logic                               part_ready;
    logic                               dot_ready;

    // stage handshakes
    assign dot_ready  = !dot_valid_reg || result.ready;
    assign part_move  = part_valid_reg && dot_ready;
    assign part_ready = !part_valid_reg || part_move;
    assign snap_move  = snap_valid_reg && part_ready;
    assign load_ready = !snap_valid_reg || snap_move;

    always_comb
    begin
        for (int g = 0; g < tsdp_pkg::GROUP_COUNT; g++)
        begin
            part_next[g] = '0;
            for (int j = 0; j < tsdp_pkg::GROUP_SIZE; j++)
            begin
                part_next[g] = part_next[g]
                    + tsdp_pkg::PART_W'($signed(snap_reg[g * tsdp_pkg::GROUP_SIZE + j]));
            end
        end
    end

    always_comb
    begin
        dot_next = '0;
        for (int g = 0; g < tsdp_pkg::GROUP_COUNT; g++)
        begin
            dot_next = dot_next + tsdp_pkg::DOT_W'(part_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            part_valid_reg <= 1'b0;
            dot_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_ready)
            begin
                snap_valid_reg <= load;
            end
            if (part_ready)
            begin
                part_valid_reg <= snap_valid_reg;
            end
            if (dot_ready)
            begin
                dot_valid_reg <= part_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            snap_reg <= lane_sum;
        end
        if (snap_move)
        begin
            part_reg <= part_next;
        end
        if (part_move)
        begin
            dot_reg <= dot_next;
        end
    end

    assign result.valid   = dot_valid_reg;
    assign result.dot_sum = dot_reg;

    assign status.snap_valid = snap_valid_reg;
    assign status.part_valid = part_valid_reg;
    assign status.dot_valid  = dot_valid_reg;

endmodule

>>> hw/rtl/ternary_sign_dot_product_top.sv
// ----------------------------------------------------------------------------
// ternary_sign_dot_product_top
// sixteen sign-select lanes accumulate chunks; a merge tree sums them on last
// ----------------------------------------------------------------------------
// throughput: one chunk per cycle while chunk.ready is high; a full merge pipe holds it low
// the last chunk's lane sums pass through the snapshot, partial sums and final
//   sum registers in that order before the result is valid
// a stalled result backs up the three merge stages before chunks are refused
// reset: lanes cleared to zero and all merge stages emptied at once
// ----------------------------------------------------------------------------
module ternary_sign_dot_product_top (
    input  logic          clk,
    input  logic          rst_n,
    tsdp_chunk_if.sink    chunk,
    tsdp_result_if.source result
);

    logic [4*tsdp_pkg::WORD_W-1:0] act_bits;
    logic [4*tsdp_pkg::WORD_W-1:0] wgt_bits;
    tsdp_pkg::acc_t                lane_sum [tsdp_pkg::LANE_COUNT];
    tsdp_pkg::merge_status_t       status;
    logic                          load_ready;
    logic                          accept;
    logic                          load;

    assign act_bits = {chunk.act_word3, chunk.act_word2, chunk.act_word1, chunk.act_word0};
    assign wgt_bits = {chunk.wgt_word3, chunk.wgt_word2, chunk.wgt_word1, chunk.wgt_word0};

    assign chunk.ready = load_ready;
    assign accept      = chunk.valid && load_ready;
    assign load        = accept && chunk.last_chunk;

    for (genvar k = 0; k < tsdp_pkg::LANE_COUNT; k++)
    begin : g_lane
        tsdp_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (accept),
            .last     (chunk.last_chunk),
            .act_lo   (act_bits[k * tsdp_pkg::BYTE_W +: tsdp_pkg::BYTE_W]),
            .act_hi   (act_bits[(k + tsdp_pkg::LANE_COUNT) * tsdp_pkg::BYTE_W
                                +: tsdp_pkg::BYTE_W]),
            .wgt_lo   (wgt_bits[k * tsdp_pkg::BYTE_W +: tsdp_pkg::BYTE_W]),
            .wgt_hi   (wgt_bits[(k + tsdp_pkg::LANE_COUNT) * tsdp_pkg::BYTE_W
                                +: tsdp_pkg::BYTE_W]),
            .lane_sum (lane_sum[k])
        );
    end

    tsdp_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .lane_sum   (lane_sum),
        .load_ready (load_ready),
        .status     (status),
        .result     (result)
    );

    // a last chunk always lands in the snapshot stage
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> status.snap_valid)
    else $error("last chunk not captured by merge stage");

    // chunks are refused only while the whole merge pipe is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !chunk.ready |-> (status.snap_valid && status.part_valid && status.dot_valid))
    else $error("chunk refused with room in merge pipe");

    // a full snapshot stage with a free partial stage advances
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.snap_valid && !status.part_valid) |=> status.part_valid)
    else $error("snapshot stage failed to advance");

endmodule
